### hw/rtl/block_rms_level_meter_top_defines.svh
// assertion macros for the rms level meter datapath
`ifndef BLOCK_RMS_LEVEL_METER_TOP_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BRLM_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BRLM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/brlm_pkg.sv
// shared constants, types and codes of the rms level meter
package brlm_pkg;

  localparam int MAX_BLOCK   = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 2 * SAMPLE_W - 1;
  localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W       = SQ_W + $clog2(MAX_BLOCK);
  localparam int REM_W       = CNT_W + 1;
  localparam int ROOT_STEPS  = SAMPLE_W;
  localparam int ROOT_REG_W  = 2 * ROOT_STEPS;
  localparam int MEAN_W      = ROOT_REG_W - 1;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int GAIN_W      = 4;
  localparam int WEIGHT_W    = 16;
  localparam int LEVEL_W     = 16;
  localparam int SCALED_W    = LEVEL_W + GAIN_W;
  localparam int PROD_W      = LEVEL_W + WEIGHT_W + 1;
  localparam int BLEND_W     = PROD_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [LEVEL_W-1:0]    FULL_SCALE     = 16'd32768;
  localparam logic [GAIN_W-1:0]     GAIN_RESET     = 4'd4;
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = 16'd26214;
  localparam logic [WEIGHT_W:0]     WEIGHT_ONE     = 17'd65536;
  localparam logic [BLEND_W-1:0]    ROUND_HALF     = BLEND_W'(32768);
  localparam logic [ROOT_REG_W-1:0] ROOT_TOP_BIT   =
    ROOT_REG_W'(1) << (2 * (ROOT_STEPS - 1));

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV,
    S_ROOT_LOAD,
    S_ROOT,
    S_SCALE,
    S_MUL_OLD,
    S_MUL_NEW
  } state_t;

  typedef struct packed {
    logic acc;
    logic load_div;
    logic div_step;
    logic load_root;
    logic root_step;
    logic scale;
    logic mul_old;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### hw/rtl/brlm_ctrl.sv
// sequencer for accumulation, divide, root, scale and blend
module brlm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_block_end,
  output logic              in_stall,
  input  brlm_pkg::status_t status,
  output brlm_pkg::cmd_t    cmd
);

  brlm_pkg::state_t state_r, state_nxt;
  logic [brlm_pkg::STEP_W-1:0] step_r, step_nxt;
  logic div_last, root_last, out_done;

  assign div_last  = (step_r == brlm_pkg::STEP_W'(brlm_pkg::DIV_STEPS - 1));
  assign root_last = (step_r == brlm_pkg::STEP_W'(brlm_pkg::ROOT_STEPS - 1));
  assign out_done  = status.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brlm_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and iteration count
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      brlm_pkg::S_IDLE: begin
        if (in_valid && in_block_end) state_nxt = brlm_pkg::S_DIV_LOAD;
      end
      brlm_pkg::S_DIV_LOAD: begin
        step_nxt  = '0;
        state_nxt = brlm_pkg::S_DIV;
      end
      brlm_pkg::S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (div_last) state_nxt = brlm_pkg::S_ROOT_LOAD;
      end
      brlm_pkg::S_ROOT_LOAD: begin
        step_nxt  = '0;
        state_nxt = brlm_pkg::S_ROOT;
      end
      brlm_pkg::S_ROOT: begin
        step_nxt = step_r + 1'b1;
        if (root_last) state_nxt = brlm_pkg::S_SCALE;
      end
      brlm_pkg::S_SCALE:   state_nxt = brlm_pkg::S_MUL_OLD;
      brlm_pkg::S_MUL_OLD: state_nxt = brlm_pkg::S_MUL_NEW;
      brlm_pkg::S_MUL_NEW: begin
        if (out_done) state_nxt = brlm_pkg::S_IDLE;
      end
      default: state_nxt = brlm_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      brlm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.acc  = in_valid;
      end
      brlm_pkg::S_DIV_LOAD:  cmd.load_div  = 1'b1;
      brlm_pkg::S_DIV:       cmd.div_step  = 1'b1;
      brlm_pkg::S_ROOT_LOAD: cmd.load_root = 1'b1;
      brlm_pkg::S_ROOT:      cmd.root_step = 1'b1;
      brlm_pkg::S_SCALE:     cmd.scale     = 1'b1;
      brlm_pkg::S_MUL_OLD:   cmd.mul_old   = 1'b1;
      brlm_pkg::S_MUL_NEW:   cmd.load_out  = out_done;
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/brlm_datapath.sv
// accumulator, serial divider, serial root, scaling and smoothing datapath
`include "block_rms_level_meter_top_defines.svh"

module brlm_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  brlm_pkg::cmd_t                       cmd,
  output brlm_pkg::status_t                    status,
  input  logic signed [brlm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 cfg_valid,
  input  logic [brlm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brlm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [brlm_pkg::LEVEL_W-1:0]         out_level,
  output logic                                 out_clipped
);

  logic [brlm_pkg::GAIN_W-1:0]     gain_r;
  logic [brlm_pkg::WEIGHT_W-1:0]   weight_r;
  logic [brlm_pkg::SUM_W-1:0]      sum_r;
  logic [brlm_pkg::CNT_W-1:0]      count_r;
  logic [brlm_pkg::LEVEL_W-1:0]    smooth_r;
  logic [brlm_pkg::SUM_W-1:0]      quot_r;
  logic [brlm_pkg::REM_W-1:0]      rem_r;
  logic [brlm_pkg::CNT_W-1:0]      divisor_r;
  logic [brlm_pkg::ROOT_REG_W-1:0] rv_r, res_r, bit_r;
  logic [brlm_pkg::LEVEL_W-1:0]    scaled_r;
  logic                            clip_r;
  logic [brlm_pkg::PROD_W-1:0]     prod_r;
  logic                            out_valid_r;
  logic [brlm_pkg::LEVEL_W-1:0]    out_level_r;
  logic                            out_clipped_r;

  logic [brlm_pkg::SAMPLE_W-1:0]   raw, mag;
  logic [brlm_pkg::ROOT_REG_W-1:0] sq_full;
  logic [brlm_pkg::REM_W-1:0]      rem_shift;
  logic                            rem_ge;
  logic [brlm_pkg::ROOT_REG_W-1:0] trial;
  logic                            root_ge;
  logic [brlm_pkg::SCALED_W-1:0]   scaled_full;
  logic [brlm_pkg::PROD_W-1:0]     new_prod;
  logic [brlm_pkg::BLEND_W-1:0]    blend_now;
  logic [brlm_pkg::BLEND_W-brlm_pkg::LEVEL_W-1:0] now_hi;
  logic [brlm_pkg::LEVEL_W-1:0]    now_level;

  assign status.out_free = !out_valid_r || !out_stall;

  // magnitude of a q1.15 sample, -1.0 maps to 32768
  assign raw     = in_sample;
  assign mag     = raw[brlm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  assign sq_full = mag * mag;

  // one restoring divide step
  assign rem_shift = {rem_r[brlm_pkg::REM_W-2:0], quot_r[brlm_pkg::SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor_r});

  // one root digit
  assign trial   = res_r + bit_r;
  assign root_ge = (rv_r >= trial);

  assign scaled_full = res_r[brlm_pkg::LEVEL_W-1:0] * gain_r;

  // blend of the old level and the new value, rounded half up
  assign new_prod  = scaled_r * weight_r;
  assign blend_now = {1'b0, prod_r} + {1'b0, new_prod} + brlm_pkg::ROUND_HALF;
  assign now_hi    = blend_now[brlm_pkg::BLEND_W-1:brlm_pkg::LEVEL_W];
  assign now_level = (now_hi > {2'b00, brlm_pkg::FULL_SCALE}) ? brlm_pkg::FULL_SCALE
                                                             : now_hi[brlm_pkg::LEVEL_W-1:0];

  // configuration and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= brlm_pkg::GAIN_RESET;
      weight_r    <= brlm_pkg::WEIGHT_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      smooth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          brlm_pkg::REG_LEVEL_GAIN: gain_r   <= cfg_data[brlm_pkg::GAIN_W-1:0];
          brlm_pkg::REG_NEW_WEIGHT: weight_r <= cfg_data[brlm_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_div) begin
        sum_r   <= '0;
        count_r <= '0;
      end else if (cmd.acc && (count_r < brlm_pkg::CNT_W'(brlm_pkg::MAX_BLOCK))) begin
        sum_r   <= sum_r + brlm_pkg::SUM_W'(sq_full[brlm_pkg::SQ_W-1:0]);
        count_r <= count_r + 1'b1;
      end
      if (cmd.load_out) smooth_r <= now_level;
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (!out_stall)  out_valid_r <= 1'b0;
    end
  end

  // iterative units and result pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quot_r    <= sum_r;
      rem_r     <= '0;
      divisor_r <= count_r;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[brlm_pkg::SUM_W-2:0], rem_ge};
      rem_r  <= rem_ge ? (rem_shift - {1'b0, divisor_r}) : rem_shift;
    end
    if (cmd.load_root) begin
      rv_r  <= {1'b0, quot_r[brlm_pkg::MEAN_W-1:0]};
      res_r <= '0;
      bit_r <= brlm_pkg::ROOT_TOP_BIT;
    end else if (cmd.root_step) begin
      if (root_ge) begin
        rv_r  <= rv_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.scale) begin
      if (scaled_full > brlm_pkg::SCALED_W'(brlm_pkg::FULL_SCALE)) begin
        scaled_r <= brlm_pkg::FULL_SCALE;
        clip_r   <= 1'b1;
      end else begin
        scaled_r <= scaled_full[brlm_pkg::LEVEL_W-1:0];
        clip_r   <= 1'b0;
      end
    end
    if (cmd.mul_old) begin
      prod_r <= smooth_r * (brlm_pkg::WEIGHT_ONE - {1'b0, weight_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_level_r   <= now_level;
      out_clipped_r <= clip_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_clipped = out_clipped_r;

  `BRLM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= brlm_pkg::CNT_W'(brlm_pkg::MAX_BLOCK),
    "sample count above block limit")
  `BRLM_ASSERT_NOW(a_level_bound, out_valid_r, out_level_r <= brlm_pkg::FULL_SCALE,
    "level above full scale")
  `BRLM_ASSERT_NEXT(a_block_clear, cmd.load_div, (sum_r == '0) && (count_r == '0),
    "accumulator not cleared at block end")
  `BRLM_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r,
    "result lost while stalled")

endmodule

### hw/rtl/block_rms_level_meter_top.sv
// top level of the block rms level meter with exponential smoothing
//
//  channel   direction  handshake          payload
//  in_       input      valid / stall      sample (s16 q1.15), block_end
//  out_      output     valid / stall      level (u16 q1.15), clipped
//  cfg_      input      valid / ready      index (0 level_gain, 1 new_weight), data
//
//  an item that does not close a block is taken as offered, one per cycle while idle
//  a closing item stalls the input through load and 43 divide steps,
//  load and 16 root steps, scale, old-level multiply, new-value multiply and load
//  reset (rst_n low, synchronous) clears the sum, count and smoothed level, and
//  restores level_gain 4 and new_weight 26214
//  a result still waiting in the output register holds the next load until taken
module block_rms_level_meter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [brlm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_block_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [brlm_pkg::LEVEL_W-1:0]         out_level,
  output logic                                 out_clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [brlm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [brlm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  brlm_pkg::cmd_t    cmd;
  brlm_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: stalls the input during the block-end arithmetic
  brlm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_block_end (in_block_end),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // accumulation, divide, root, gain and smoothing
  brlm_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_sample   (in_sample),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_level   (out_level),
    .out_clipped (out_clipped)
  );

endmodule

### dv/block_rms_level_meter_top_tb.sv
// self-checking testbench for the block rms level meter with exponential smoothing
`timescale 1ns / 1ps

module block_rms_level_meter_top_tb;

  // one input item as queued for the driver; hold makes the driver wait until no reading is pending
  typedef struct {
    logic signed [brlm_pkg::SAMPLE_W-1:0] sample;
    logic                                 block_end;
    bit                                   hold;
  } sample_item_t;

  // one level reading as the block should report it
  typedef struct {
    logic [brlm_pkg::LEVEL_W-1:0] level;
    logic                         clipped;
  } meter_reading_t;

  // amplitude profiles for random sample content
  typedef enum int unsigned {
    AMP_FULL,
    AMP_QUIET,
    AMP_EDGE,
    AMP_MID,
    AMP_MIX
  } amp_kind_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [brlm_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                 in_block_end = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [brlm_pkg::LEVEL_W-1:0]         out_level;
  logic                                 out_clipped;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [brlm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [brlm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  block_rms_level_meter_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_level    (out_level),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // items waiting to be driven, readings waiting to come out
  sample_item_t   sample_backlog[$];
  meter_reading_t pending_readings[$];

  // predictor copy of the block's registers and state
  bit [brlm_pkg::GAIN_W-1:0]   gain_now;
  bit [brlm_pkg::WEIGHT_W-1:0] weight_now;
  bit [brlm_pkg::SUM_W-1:0]    sq_sum;
  bit [brlm_pkg::CNT_W-1:0]    blk_cnt;
  bit [brlm_pkg::LEVEL_W-1:0]  smooth_lvl;

  // handshake bookkeeping and random idling
  bit          idle_on = 1'b1;
  bit          in_took;
  bit          out_took;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned bad_readings;

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("block_rms_level_meter_top test failed");
    $finish;
  end

  // floor of the square root, built up one result bit at a time
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // advance the predicted meter by one accepted item, queue a reading on a block end
  task automatic track_sample(logic signed [brlm_pkg::SAMPLE_W-1:0] s, logic last);
    longint          sval;
    longint unsigned mag;
    longint unsigned mean;
    longint unsigned scaled;
    longint unsigned mix;
    meter_reading_t  want;
    sval = s;
    mag  = (sval < 0) ? -sval : sval;
    // once the block is full, further samples (the closing one too) are dropped
    if (blk_cnt < brlm_pkg::MAX_BLOCK) begin
      sq_sum  = sq_sum + mag * mag;
      blk_cnt = blk_cnt + 1'b1;
    end
    if (last) begin
      mean         = 64'(sq_sum) / 64'(blk_cnt);
      scaled       = root_floor(mean) * 64'(gain_now);
      // exactly full scale is not a clip, only above it
      want.clipped = (scaled > 64'(brlm_pkg::FULL_SCALE));
      if (want.clipped) scaled = 64'(brlm_pkg::FULL_SCALE);
      // blend with rounding half up
      mix = 64'(smooth_lvl) * (64'(brlm_pkg::WEIGHT_ONE) - 64'(weight_now))
          + scaled * 64'(weight_now) + 64'd32768;
      smooth_lvl = ((mix >> 16) > 64'(brlm_pkg::FULL_SCALE)) ? brlm_pkg::FULL_SCALE
                                                             : brlm_pkg::LEVEL_W'(mix >> 16);
      want.level = smooth_lvl;
      pending_readings = {pending_readings, want};
      sq_sum  = '0;
      blk_cnt = '0;
    end
  endtask

  // sampling at the rising edge: config tracking, prediction and reading checks
  always @(posedge clk) begin : monitor
    meter_reading_t want;
    if (!rst_n) begin
      gain_now   = brlm_pkg::GAIN_RESET;
      weight_now = brlm_pkg::WEIGHT_RESET;
      sq_sum     = '0;
      blk_cnt    = '0;
      smooth_lvl = '0;
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected reading: level %0d, clipped %0d", out_level, out_clipped);
          bad_readings++;
        end else begin
          want = pending_readings.pop_front();
          if (out_level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, out_level);
            bad_readings++;
          end
          if (out_clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, out_clipped);
            bad_readings++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          brlm_pkg::REG_LEVEL_GAIN: gain_now   = cfg_data[brlm_pkg::GAIN_W-1:0];
          brlm_pkg::REG_NEW_WEIGHT: weight_now = cfg_data[brlm_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_sample(in_sample, in_block_end);
    end
  end

  // sender: holds a stalled item, then waits its drawn gap before the next one
  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_took) begin
      // stalled item stays as it is
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sample_backlog.size() != 0 &&
                 !(sample_backlog[0].hold && pending_readings.size() != 0)) begin
      in_valid     <= 1'b1;
      in_sample    <= sample_backlog[0].sample;
      in_block_end <= sample_backlog[0].block_end;
      void'(sample_backlog.pop_front());
      gap_left <= idle_on ? $urandom_range(0, 7) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: a fresh stall count per reading, counted down while a reading is offered
  always @(negedge clk) begin : receiver
    int unsigned hold_n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold_n = out_took ? (idle_on ? $urandom_range(0, 7) : 0) : stall_left;
      out_stall  <= (hold_n != 0);
      stall_left <= (out_valid && hold_n != 0) ? hold_n - 1 : hold_n;
    end
  end

  function automatic logic signed [brlm_pkg::SAMPLE_W-1:0] pick_sample(amp_kind_t kind);
    logic signed [brlm_pkg::SAMPLE_W-1:0] w;
    int                                   v;
    if (kind == AMP_MIX) kind = amp_kind_t'($urandom_range(0, 3));
    w = brlm_pkg::SAMPLE_W'($urandom);
    case (kind)
      AMP_QUIET: begin
        v = $urandom_range(0, 255);
        return brlm_pkg::SAMPLE_W'(v - 128);
      end
      AMP_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      AMP_MID:  return w >>> 4;
      default:  return w;
    endcase
  endfunction

  task automatic queue_value(logic signed [brlm_pkg::SAMPLE_W-1:0] s, logic last, bit hold);
    sample_item_t it;
    it.sample    = s;
    it.block_end = last;
    it.hold      = hold;
    sample_backlog = {sample_backlog, it};
  endtask

  // one block of random content, closed by its last item
  task automatic queue_block(int unsigned len, amp_kind_t kind, bit hold_first);
    for (int unsigned k = 0; k < len; k++)
      queue_value(pick_sample(kind), k == len - 1, hold_first && k == 0);
  endtask

  // wait for the backlog to empty and every reading to arrive, then let the block settle
  task automatic drain_all();
    while (sample_backlog.size() != 0 || in_valid || pending_readings.size() != 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [brlm_pkg::CFG_IDX_W-1:0] idx,
                           logic [brlm_pkg::CFG_DATA_W-1:0] word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned queued;
    int unsigned len;
    logic [brlm_pkg::CFG_DATA_W-1:0] gain_word;
    logic [brlm_pkg::CFG_DATA_W-1:0] weight_word;

    // synchronous reset held low from the start, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with the reset gain and weight: field extremes and short blocks
    queue_value(16'sh8000, 1'b1, 1'b0);
    queue_value(16'sh7fff, 1'b1, 1'b0);
    queue_value(16'sh0000, 1'b1, 1'b0);
    // sender waits here until all readings so far are in
    queue_value(16'shffff, 1'b0, 1'b1);
    queue_value(16'sh0001, 1'b1, 1'b0);
    queue_value(16'sh7fff, 1'b0, 1'b0);
    queue_value(16'sh8000, 1'b0, 1'b0);
    queue_value(16'sh3039, 1'b0, 1'b0);
    queue_value(16'shcfc7, 1'b1, 1'b0);
    drain_all();

    // zero gain: scaled value is zero and never clips
    write_reg(brlm_pkg::REG_LEVEL_GAIN, 16'h0000);
    queue_value(16'sh8000, 1'b1, 1'b0);
    drain_all();

    // top gain with upper data bits set, weight almost one
    write_reg(brlm_pkg::REG_LEVEL_GAIN, 16'hffff);
    write_reg(brlm_pkg::REG_NEW_WEIGHT, 16'hffff);
    queue_value(16'sh8000, 1'b1, 1'b0);
    queue_value(16'sh0001, 1'b1, 1'b0);
    queue_value(16'shf800, 1'b1, 1'b0);
    drain_all();

    // zero weight keeps the old level
    write_reg(brlm_pkg::REG_NEW_WEIGHT, 16'h0000);
    queue_value(16'sh012c, 1'b1, 1'b0);
    drain_all();

    // scaled value landing exactly on full scale is not a clip
    write_reg(brlm_pkg::REG_LEVEL_GAIN, 16'h0001);
    write_reg(brlm_pkg::REG_NEW_WEIGHT, 16'hffff);
    queue_value(16'sh8000, 1'b1, 1'b0);
    drain_all();
    write_reg(brlm_pkg::REG_LEVEL_GAIN, 16'h0002);
    queue_value(16'shc000, 1'b1, 1'b0);
    drain_all();

    // random phases, each under its own gain and weight, one phase without idling
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin gain_word = 16'h0001; weight_word = 16'hffff; end
        1: begin gain_word = 16'h000f; weight_word = 16'h0000; end
        2: begin gain_word = 16'hfff0; weight_word = 16'h8000; end
        default: begin
          gain_word   = brlm_pkg::CFG_DATA_W'($urandom);
          weight_word = brlm_pkg::CFG_DATA_W'($urandom);
        end
      endcase
      write_reg(brlm_pkg::REG_LEVEL_GAIN, gain_word);
      write_reg(brlm_pkg::REG_NEW_WEIGHT, weight_word);
      idle_on = (p != 3);
      queued = 0;
      while (queued < 70) begin
        // mostly short blocks, now and then a longer one
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 12);
        queue_block(len, amp_kind_t'($urandom_range(0, 4)), $urandom_range(0, 9) == 0);
        queued += len;
      end
      drain_all();
    end

    if (bad_readings == 0 && pending_readings.size() == 0) begin
      $display("block_rms_level_meter_top test passed");
    end else begin
      $display("block_rms_level_meter_top test failed");
    end
    $finish;
  end

endmodule
